[hw/rtl/dpt_pkg.sv]
// ----------------------------------------------------------------------------
// dpt_pkg
// Types, constants and command codes shared by the dated priority table.
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int unsigned Depth    = 16;
  localparam int unsigned SlotBits = $clog2(Depth);
  localparam int unsigned CntBits  = SlotBits + 1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_LIST  = 2'd2,
    OP_COUNT = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] date_year;
    logic [3:0]  date_month;
    logic [4:0]  date_day;
    logic [7:0]  entry_priority;
    logic [31:0] payload_handle;
    logic        payload_present;
    logic [15:0] target_id;
    logic [4:0]  list_limit;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        success;
    logic [15:0] entry_id;
    logic [7:0]  listed_priority;
    logic [31:0] listed_payload;
    logic [4:0]  date_count;
    logic        update_posted;
    logic        last_of_run;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input word
    logic scan_clr;    // clear scan accumulators
    logic scan_step;   // examine slot scan_idx
    logic [SlotBits-1:0] scan_idx;
    logic pick_pass;   // selection only, leave the match count alone
    logic cnt_clr;     // restart the match count before a recount
    logic do_add;      // write new entry
    logic do_del;      // invalidate found entry
    logic use_del_date; // count on the deleted entry's date
    logic pick_clr;    // begin one list selection pass
    logic pick_take;   // mark picked slot as listed
    logic emit;        // load output register
    logic [1:0] emit_kind;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic present;
    logic found;       // delete hit
    logic pick_any;    // selection pass found an entry
    logic list_last;   // picked entry is the last one to list
    logic out_busy;
  } dp_sts_t;

endpackage

[hw/rtl/dpt_datapath.sv]
// ----------------------------------------------------------------------------
// dpt_datapath
// Slot storage, per-slot scan accumulators and the output word register.
// ----------------------------------------------------------------------------
module dpt_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dpt_pkg::in_word_t  in_word_i,
  input  dpt_pkg::dp_cmd_t   cmd_i,
  output dpt_pkg::dp_sts_t   sts_o,
  output dpt_pkg::out_word_t out_word_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);
  import dpt_pkg::*;

  logic [Depth-1:0] valid_q;
  logic [Depth-1:0] listed_q;
  logic [15:0] id_q   [Depth];
  logic [11:0] year_q [Depth];
  logic [3:0]  month_q[Depth];
  logic [4:0]  day_q  [Depth];
  logic [7:0]  prio_q [Depth];
  logic [31:0] pay_q  [Depth];

  in_word_t    req_q;
  logic [15:0] next_id_q;
  // scan accumulators
  logic                free_hit_q;
  logic [SlotBits-1:0] free_q;
  logic [SlotBits-1:0] low_q;
  logic                found_q;
  logic [SlotBits-1:0] found_idx_q;
  logic [CntBits-1:0]  cnt_q;
  logic                pick_any_q;
  logic [SlotBits-1:0] pick_q;
  logic [CntBits-1:0]  nlist_q;
  logic [11:0] dy_q;
  logic [3:0]  dm_q;
  logic [4:0]  dd_q;

  out_word_t out_q, out_d;
  logic      out_valid_q;

  logic [SlotBits-1:0] si;
  logic match;
  logic cand;
  logic [CntBits-1:0] cap;
  logic [CntBits-1:0] nsel;
  logic list_last;

  assign si    = cmd_i.scan_idx;
  assign match = valid_q[si] && year_q[si] == dy_q && month_q[si] == dm_q && day_q[si] == dd_q;
  assign cand  = match && !listed_q[si];
  assign cap   = (req_q.list_limit > 5'(Depth)) ? CntBits'(Depth)
                                                : CntBits'(req_q.list_limit);
  // entries a list returns in total
  assign nsel      = (cnt_q < cap) ? cnt_q : cap;
  assign list_last = (nlist_q + 1'b1 >= nsel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      next_id_q   <= 16'd1;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Depth; i++) prio_q[i] <= '0;
    end else begin
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.do_add) begin
        valid_q[free_hit_q ? free_q : low_q] <= 1'b1;
        prio_q[free_hit_q ? free_q : low_q]  <= req_q.entry_priority;
        next_id_q <= (next_id_q == 16'hffff) ? 16'd1 : next_id_q + 16'd1;
      end
      if (cmd_i.do_del) valid_q[found_idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_word_i;
      dy_q  <= in_word_i.date_year;
      dm_q  <= in_word_i.date_month;
      dd_q  <= in_word_i.date_day;
      listed_q <= '0;
      nlist_q  <= '0;
    end
    if (cmd_i.use_del_date) begin
      dy_q <= year_q[found_idx_q];
      dm_q <= month_q[found_idx_q];
      dd_q <= day_q[found_idx_q];
    end
    if (cmd_i.do_add) begin
      id_q   [free_hit_q ? free_q : low_q] <= next_id_q;
      year_q [free_hit_q ? free_q : low_q] <= req_q.date_year;
      month_q[free_hit_q ? free_q : low_q] <= req_q.date_month;
      day_q  [free_hit_q ? free_q : low_q] <= req_q.date_day;
      pay_q  [free_hit_q ? free_q : low_q] <= req_q.payload_handle;
    end
    if (cmd_i.scan_clr) begin
      free_hit_q <= 1'b0;
      free_q     <= '0;
      low_q      <= '0;
      found_q    <= 1'b0;
      found_idx_q <= '0;
      cnt_q      <= '0;
      pick_any_q <= 1'b0;
      pick_q     <= '0;
    end else if (cmd_i.scan_step) begin
      if (!valid_q[si] && !free_hit_q) begin
        free_hit_q <= 1'b1;
        free_q     <= si;
      end
      if (prio_q[si] < prio_q[low_q]) low_q <= si;
      if (!found_q && valid_q[si] && id_q[si] == req_q.target_id &&
          req_q.target_id != 16'd0) begin
        found_q     <= 1'b1;
        found_idx_q <= si;
      end
      if (match && !cmd_i.pick_pass) cnt_q <= cnt_q + 1'b1;
      // strict compare keeps the earliest slot on ties
      if (cand && (!pick_any_q || prio_q[si] > prio_q[pick_q])) begin
        pick_any_q <= 1'b1;
        pick_q     <= si;
      end
    end
    if (cmd_i.cnt_clr) cnt_q <= '0;
    if (cmd_i.pick_clr) begin
      pick_any_q <= 1'b0;
      pick_q     <= '0;
    end
    if (cmd_i.pick_take) begin
      listed_q[pick_q] <= 1'b1;
      nlist_q <= nlist_q + 1'b1;
    end
    if (cmd_i.emit) out_q <= out_d;
  end

  always_comb begin
    out_d = '0;
    out_d.result_kind = cmd_i.emit_kind;
    out_d.last_of_run = 1'b1;
    unique case (op_e'(cmd_i.emit_kind))
      OP_ADD: if (req_q.payload_present) begin
        out_d.success       = 1'b1;
        // counter has already moved past the id just written
        out_d.entry_id      = (next_id_q == 16'd1) ? 16'hffff : next_id_q - 16'd1;
        out_d.date_count    = 5'(cnt_q);
        out_d.update_posted = 1'b1;
      end
      OP_DEL: if (found_q) begin
        out_d.success       = 1'b1;
        out_d.date_count    = 5'(cnt_q);
        out_d.update_posted = 1'b1;
      end
      OP_LIST: if (pick_any_q && nsel != '0) begin
        out_d.success         = 1'b1;
        out_d.entry_id        = id_q[pick_q];
        out_d.listed_priority = prio_q[pick_q];
        out_d.listed_payload  = pay_q[pick_q];
        out_d.date_count      = 5'(nsel);
        out_d.last_of_run     = list_last;
      end
      OP_COUNT: out_d.date_count = 5'(cnt_q);
      default: ;
    endcase
  end

  assign sts_o.op        = op_e'(req_q.operation);
  assign sts_o.present   = req_q.payload_present;
  assign sts_o.found     = found_q;
  assign sts_o.pick_any  = pick_any_q;
  assign sts_o.list_last = list_last;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign out_word_o      = out_q;
  assign out_valid_o     = out_valid_q;

endmodule

[hw/rtl/dpt_ctrl.sv]
// ----------------------------------------------------------------------------
// dpt_ctrl
// Sequencer: slot scans, table update and result emission.
// ----------------------------------------------------------------------------
module dpt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dpt_pkg::dp_sts_t sts_i,
  output dpt_pkg::dp_cmd_t cmd_o
);
  import dpt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_ADD   = 8'b0000_0100,
    S_DEL   = 8'b0000_1000,
    S_CNT   = 8'b0001_0000,
    S_EMIT  = 8'b0010_0000,
    S_PICK  = 8'b0100_0000,
    S_LEMIT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [SlotBits-1:0] idx_q, idx_d;
  logic last_idx;

  assign last_idx = idx_q == SlotBits'(Depth - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    cmd_o.scan_idx  = idx_q;
    cmd_o.emit_kind = sts_i.op;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = !sts_i.out_busy;
        if (in_valid_i && !sts_i.out_busy) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.op == OP_LIST) begin
          // one full pass settles the match count and the first pick
          cmd_o.scan_step = 1'b1;
          idx_d = idx_q + 1'b1;
          if (last_idx) state_d = S_LEMIT;
        end else if (sts_i.op == OP_ADD && !sts_i.present) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.scan_step = 1'b1;
          idx_d = idx_q + 1'b1;
          if (last_idx) begin
            unique case (sts_i.op)
              OP_ADD:  state_d = S_ADD;
              OP_DEL:  state_d = S_DEL;
              default: state_d = S_EMIT;
            endcase
          end
        end
      end
      S_ADD: begin
        cmd_o.do_add  = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        state_d = S_CNT;
      end
      S_DEL: begin
        if (sts_i.found) begin
          cmd_o.do_del       = 1'b1;
          cmd_o.use_del_date = 1'b1;
          cmd_o.cnt_clr      = 1'b1;
          state_d = S_CNT;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_CNT: begin
        // recount matches on the affected date after the change
        cmd_o.scan_step = 1'b1;
        idx_d = idx_q + 1'b1;
        if (last_idx) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PICK: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.pick_pass = 1'b1;
        idx_d = idx_q + 1'b1;
        if (last_idx) state_d = S_LEMIT;
      end
      S_LEMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          if (!sts_i.pick_any || sts_i.list_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.pick_take = 1'b1;
            cmd_o.pick_clr  = 1'b1;
            state_d = S_PICK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/dated_priority_table.sv]
// ----------------------------------------------------------------------------
// dated_priority_table
// Table of dated, prioritised entries with add, delete, list and count.
// ----------------------------------------------------------------------------
// Usage: present one command word on in_word_i with in_valid_i; it is taken
// when in_ready_o is high. Results leave on out_word_o under out_valid_o and
// out_ready_i; every command gives one word except a list, which gives one
// word per listed entry (highest priority first, one blank word if none is),
// last_of_run marking the end. Timing: a command is taken only while the
// sequencer is idle. Add, delete and count walk the sixteen slots one per
// cycle; an add with a payload and a delete that finds its id then walk again
// to recount the date, while a rejected add skips the walk. A list's first
// pass counts and picks the first entry; each further word needs another
// selection pass over the slots.
// Reset empties the table and restarts ids at one; the output valid is
// cleared. If the receiver stalls, the sequencer holds in its emit state while
// a word is pending; no new command is taken until that word has gone.
// ----------------------------------------------------------------------------
module dated_priority_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dpt_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dpt_pkg::out_word_t out_word_o
);
  import dpt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dpt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_word_o  (out_word_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

[tb/sv/tb_dated_priority_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dated_priority_table
// Drives add, delete, list and count words into the dated priority table,
// keeps a shadow table to predict every result word and checks each one.
// ----------------------------------------------------------------------------
module tb_dated_priority_table;
  import dpt_pkg::*;

  localparam int unsigned Slots = 16;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  dated_priority_table dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_word_i,
    .out_valid_o, .out_ready_i, .out_word_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow table
  logic        tbl_valid [Slots];
  logic [15:0] tbl_id [Slots];
  logic [11:0] tbl_year [Slots];
  logic [3:0]  tbl_month [Slots];
  logic [4:0]  tbl_day [Slots];
  logic [7:0]  tbl_pri [Slots];
  logic [31:0] tbl_pay [Slots];
  logic [15:0] id_next;

  out_word_t expected_words[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        failed = 1'b0;

  function automatic bit on_date(int s, logic [11:0] y, logic [3:0] m, logic [4:0] d);
    return tbl_valid[s] && tbl_year[s] == y && tbl_month[s] == m && tbl_day[s] == d;
  endfunction

  function automatic logic [4:0] date_total(logic [11:0] y, logic [3:0] m, logic [4:0] d);
    int c = 0;
    for (int s = 0; s < Slots; s++) if (on_date(s, y, m, d)) c++;
    return (c > 31) ? 5'd31 : c[4:0];
  endfunction

  function automatic out_word_t blank_word(logic [1:0] kind);
    out_word_t w = '0;
    w.result_kind = kind;
    w.last_of_run = 1'b1;
    return w;
  endfunction

  task automatic predict_table(in_word_t w);
    out_word_t r;
    int        slot;
    int        cap;
    int        n;
    int        at;
    int        pick [Slots];
    r = '0;
    case (op_e'(w.operation))
      OP_ADD: begin
        if (!w.payload_present) begin
          expected_words.push_back(blank_word(OP_ADD));
        end else begin
          slot = -1;
          for (int s = 0; s < Slots; s++) if (slot < 0 && !tbl_valid[s]) slot = s;
          if (slot < 0) begin
            slot = 0;
            for (int s = 1; s < Slots; s++) if (tbl_pri[s] < tbl_pri[slot]) slot = s;
          end
          tbl_id[slot] = id_next;
          tbl_year[slot] = w.date_year;
          tbl_month[slot] = w.date_month;
          tbl_day[slot] = w.date_day;
          tbl_pri[slot] = w.entry_priority;
          tbl_pay[slot] = w.payload_handle;
          tbl_valid[slot] = 1'b1;
          r = blank_word(OP_ADD);
          r.success = 1'b1;
          r.entry_id = id_next;
          r.date_count = date_total(w.date_year, w.date_month, w.date_day);
          r.update_posted = 1'b1;
          expected_words.push_back(r);
          id_next = id_next + 16'd1;
          if (id_next == 16'd0) id_next = 16'd1;
        end
      end
      OP_DEL: begin
        slot = -1;
        if (w.target_id != 16'd0)
          for (int s = 0; s < Slots; s++)
            if (slot < 0 && tbl_valid[s] && tbl_id[s] == w.target_id) slot = s;
        r = blank_word(OP_DEL);
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b0;
          r.success = 1'b1;
          r.date_count = date_total(tbl_year[slot], tbl_month[slot], tbl_day[slot]);
          r.update_posted = 1'b1;
        end
        expected_words.push_back(r);
      end
      OP_LIST: begin
        cap = (w.list_limit > Slots) ? Slots : w.list_limit;
        n = 0;
        // insertion keeps earlier slots ahead on equal priority
        for (int s = 0; s < Slots && cap > 0; s++) begin
          if (!on_date(s, w.date_year, w.date_month, w.date_day)) continue;
          at = n;
          while (at > 0 && tbl_pri[pick[at-1]] < tbl_pri[s]) begin
            if (at < cap) pick[at] = pick[at-1];
            at--;
          end
          if (at < cap) pick[at] = s;
          if (n < cap) n++;
        end
        if (n == 0) expected_words.push_back(blank_word(OP_LIST));
        for (int i = 0; i < n; i++) begin
          r = '0;
          r.result_kind = OP_LIST;
          r.success = 1'b1;
          r.entry_id = tbl_id[pick[i]];
          r.listed_priority = tbl_pri[pick[i]];
          r.listed_payload = tbl_pay[pick[i]];
          r.date_count = n[4:0];
          r.last_of_run = (i == n - 1);
          expected_words.push_back(r);
        end
      end
      default: begin
        r = blank_word(OP_COUNT);
        r.date_count = date_total(w.date_year, w.date_month, w.date_day);
        expected_words.push_back(r);
      end
    endcase
  endtask

  task automatic send_word(in_word_t w);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_table(w);
  endtask

  // receiver: random stall, check at each accepted word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %p", $time, out_word_o);
        failed = 1'b1;
      end else if (out_word_o !== expected_words[0]) begin
        $display("%0t mismatch: expected %p, actual %p", $time, expected_words[0],
                 out_word_o);
        failed = 1'b1;
        void'(expected_words.pop_front());
      end else begin
        void'(expected_words.pop_front());
      end
    end
    out_ready_i <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  function automatic in_word_t make_word(op_e op, logic [11:0] y, logic [3:0] m,
                                         logic [4:0] d, logic [7:0] p, logic [15:0] tid,
                                         logic [4:0] lim);
    in_word_t w;
    w.operation = op;
    w.date_year = y;
    w.date_month = m;
    w.date_day = d;
    w.entry_priority = p;
    w.payload_handle = $urandom;
    w.payload_present = 1'b1;
    w.target_id = tid;
    w.list_limit = lim;
    return w;
  endfunction

  task automatic test_directed();
    in_word_t w;
    w = make_word(OP_ADD, 12'hfff, 4'd15, 5'd31, 8'hff, 16'hffff, 5'd31);
    w.payload_present = 1'b0;
    send_word(w);                                                          // rejected add
    send_word(make_word(OP_LIST, 12'd5, 4'd1, 5'd1, 8'd0, 16'd0, 5'd4));   // empty list
    send_word(make_word(OP_DEL, 12'd0, 4'd0, 5'd0, 8'd0, 16'd0, 5'd0));    // id zero
    send_word(make_word(OP_DEL, 12'd0, 4'd0, 5'd0, 8'd0, 16'd7, 5'd0));    // no such id
    w = make_word(OP_ADD, 12'hfff, 4'd15, 5'd31, 8'hff, 16'hffff, 5'd31);
    w.payload_handle = 32'hffff_ffff;
    send_word(w);
    w = make_word(OP_ADD, 12'd0, 4'd0, 5'd0, 8'd0, 16'd0, 5'd0);
    w.payload_handle = 32'd0;
    send_word(w);
    // fill past capacity on one date to force evictions
    for (int i = 0; i < 17; i++)
      send_word(make_word(OP_ADD, 12'd2024, 4'd6, 5'd15, 8'(i % 5), 16'd0, 5'd0));
    send_word(make_word(OP_LIST, 12'd2024, 4'd6, 5'd15, 8'd0, 16'd0, 5'd31));
    send_word(make_word(OP_LIST, 12'd2024, 4'd6, 5'd15, 8'd0, 16'd0, 5'd0));
    send_word(make_word(OP_LIST, 12'd2024, 4'd6, 5'd15, 8'd0, 16'd0, 5'd3));
    send_word(make_word(OP_COUNT, 12'd2024, 4'd6, 5'd15, 8'd0, 16'd0, 5'd0));
    send_word(make_word(OP_DEL, 12'd0, 4'd0, 5'd0, 8'd0, 16'd5, 5'd0));
  endtask

  task automatic test_random(int items);
    in_word_t w;
    int       r;
    for (int i = 0; i < items; i++) begin
      w = make_word(op_e'($urandom_range(3)), 12'(2000 + $urandom_range(1)),
                    4'($urandom_range(1, 2)), 5'($urandom_range(1, 2)),
                    8'($urandom_range(7)), 16'($urandom_range(0, id_next + 1)),
                    5'($urandom_range(0, 18)));
      r = $urandom_range(9);
      if (r == 0) w = in_word_t'({$urandom, $urandom, $urandom});  // noise
      else if (r == 1) w.payload_present = 1'b0;
      else if (r == 2) w.entry_priority = 8'($urandom);
      send_word(w);
    end
  endtask

  task automatic test_id_wrap();
    // add and delete in turn so the ids keep moving
    for (int i = 0; i < 16; i++) begin
      send_word(make_word(OP_ADD, 12'd1, 4'd1, 5'd1, 8'd200, 16'd0, 5'd0));
      send_word(make_word(OP_DEL, 12'd0, 4'd0, 5'd0, 8'd0, id_next - 16'd1, 5'd0));
    end
  endtask

  initial begin
    for (int s = 0; s < Slots; s++) begin
      tbl_valid[s] = 1'b0;
      tbl_pri[s] = '0;
    end
    id_next = 16'd1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 26;
    recv_idle_pct = 46;
    test_directed();
    test_random(50);
    send_idle_pct = 46;
    recv_idle_pct = 26;
    test_random(50);
    test_id_wrap();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(20);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (!failed && expected_words.size() == 0) begin
      $display("dated_priority_table test passed");
    end else begin
      $display("dated_priority_table test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("dated_priority_table test failed");
    $finish;
  end

endmodule
